// ===== src/bb3_pkg.sv =====
// Shared constants and types for the 3x3 RGB box blur.
package bb3_pkg;

  localparam int MAX_SIDE = 1024;
  localparam int CHANNEL_BITS = 16;
  localparam int ADDR_W = $clog2(MAX_SIDE);
  localparam int SIZE_W = 11;
  localparam int PIX_W = 3 * CHANNEL_BITS;
  localparam int SUM_W = CHANNEL_BITS + 4;
  localparam int RCP_W = 20;
  localparam int PROD_W = SUM_W + RCP_W;

  // Neighborhood size of one result: 9 inside, 6 on an edge, 4 at a corner.
  typedef enum logic [1:0] {
    DIV_9 = 2'd0,
    DIV_6 = 2'd1,
    DIV_4 = 2'd2
  } div_e;

  // Reciprocals: floor(x * M / 2^S) equals floor(x / d) for all sums here.
  localparam logic [RCP_W-1:0] RCP_9 = RCP_W'(932068);
  localparam logic [RCP_W-1:0] RCP_6 = RCP_W'(699051);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'(1);
  localparam int SHIFT_9 = 23;
  localparam int SHIFT_6 = 22;
  localparam int SHIFT_4 = 2;

endpackage

// ===== src/box_blur_3x3_rgb.sv =====
// 3x3 box blur over a streamed square RGB image with two line memories.
// The first result of a request passes the window, sum and product stages to reach out_valid_o.
// At most one result per cycle, while out_stall_i is low; a request occupies the window stage
// until every result it causes is emitted (one in the body, up to four at the end of the last row).
// The line memories have one read port each, read when a request is accepted.
// Reset (rst_ni low, asynchronous) clears counters, window and valids; size returns to 32.
module box_blur_3x3_rgb import bb3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [15:0]             in_red_i,
  input  logic [15:0]             in_green_i,
  input  logic [15:0]             in_blue_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [15:0]             out_red_o,
  output logic [15:0]             out_green_o,
  output logic [15:0]             out_blue_o,
  output logic [9:0]              out_row_o,
  output logic [9:0]              out_col_o,
  output logic                    frame_done_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [SIZE_W-1:0]       cfg_image_size_i
);

  // Configuration and raster position of the next request.
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] row_q, col_q;
  logic [ADDR_W-1:0] last;

  always_comb begin
    if (size_q < SIZE_W'(2)) begin
      last = ADDR_W'(1);
    end else if (size_q > SIZE_W'(MAX_SIDE)) begin
      last = ADDR_W'(MAX_SIDE - 1);
    end else begin
      last = ADDR_W'(size_q - SIZE_W'(1));
    end
  end

  assign cfg_ready_o = 1'b1;

  // Line memories: row r-2 and row r-1 of the current column.
  logic [PIX_W-1:0] older_mem [MAX_SIDE];
  logic [PIX_W-1:0] newer_mem [MAX_SIDE];
  logic [PIX_W-1:0] older_rd_q, newer_rd_q;

  // Window stage: one request with its memory data and a mask of results still to emit.
  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [ADDR_W-1:0] s1_row_q, s1_col_q, s1_last_q;
  logic [3:0]        s1_pend_q;
  logic [PIX_W-1:0]  wc_q [2][3];

  // Pipeline advances whenever the output register is free or being taken.
  logic adv, accept, s1_leave;
  logic [3:0] pend_nxt, emit_sel;

  assign adv = !out_valid_o || !out_stall_i;

  always_comb begin
    emit_sel = 4'b0000;
    if (s1_pend_q[0]) begin
      emit_sel = 4'b0001;
    end else if (s1_pend_q[1]) begin
      emit_sel = 4'b0010;
    end else if (s1_pend_q[2]) begin
      emit_sel = 4'b0100;
    end else if (s1_pend_q[3]) begin
      emit_sel = 4'b1000;
    end
  end

  assign pend_nxt = s1_pend_q & ~emit_sel;
  assign s1_leave = s1_valid_q && adv && (pend_nxt == 4'b0000);
  assign in_stall_o = s1_valid_q && !s1_leave;
  assign accept = in_valid_i && !in_stall_o;

  // Results caused at the incoming pixel, in delivery order.
  logic [3:0] pend_new;
  always_comb begin
    pend_new[0] = (row_q != '0) && (col_q != '0);
    pend_new[1] = (row_q == last) && (col_q != '0);
    pend_new[2] = (col_q == last) && (row_q != '0);
    pend_new[3] = (col_q == last) && (row_q == last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(32);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_image_size_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (accept) begin
      if (col_q == last) begin
        col_q <= '0;
        row_q <= (row_q == last) ? '0 : row_q + ADDR_W'(1);
      end else begin
        col_q <= col_q + ADDR_W'(1);
      end
    end
  end

  // Reads happen on accept; the write-back of a column happens when its request leaves,
  // and the next request addresses another column (a configuration write aside), so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      older_rd_q <= older_mem[col_q];
      newer_rd_q <= newer_mem[col_q];
    end
    if (s1_leave) begin
      older_mem[s1_col_q] <= newer_rd_q;
      newer_mem[s1_col_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= {in_blue_i[CHANNEL_BITS-1:0], in_green_i[CHANNEL_BITS-1:0],
                    in_red_i[CHANNEL_BITS-1:0]};
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pend_q  <= '0;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) begin
          wc_q[i][j] <= '0;
        end
      end
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_pend_q  <= pend_new;
      end else if (s1_leave) begin
        s1_valid_q <= 1'b0;
        s1_pend_q  <= '0;
      end else if (s1_valid_q && adv) begin
        s1_pend_q <= pend_nxt;
      end
      if (s1_leave) begin
        wc_q[0][0] <= wc_q[1][0];
        wc_q[0][1] <= wc_q[1][1];
        wc_q[0][2] <= wc_q[1][2];
        wc_q[1][0] <= older_rd_q;
        wc_q[1][1] <= newer_rd_q;
        wc_q[1][2] <= s1_pix_q;
      end
    end
  end

  // Pick the neighborhood of the result being emitted.
  logic              rlo, clo, done_sel;
  logic [ADDR_W-1:0] row_sel, col_sel;
  logic [PIX_W-1:0]  win [3][3];

  always_comb begin
    win[0][0] = wc_q[0][0];
    win[0][1] = wc_q[0][1];
    win[0][2] = wc_q[0][2];
    win[1][0] = wc_q[1][0];
    win[1][1] = wc_q[1][1];
    win[1][2] = wc_q[1][2];
    win[2][0] = older_rd_q;
    win[2][1] = newer_rd_q;
    win[2][2] = s1_pix_q;
    rlo      = (s1_row_q < ADDR_W'(2));
    clo      = (s1_col_q < ADDR_W'(2));
    row_sel  = s1_row_q - ADDR_W'(1);
    col_sel  = s1_col_q - ADDR_W'(1);
    done_sel = 1'b0;
    if (emit_sel[1]) begin
      rlo     = 1'b1;
      row_sel = s1_row_q;
    end else if (emit_sel[2]) begin
      clo     = 1'b1;
      col_sel = s1_last_q;
    end else if (emit_sel[3]) begin
      rlo      = 1'b1;
      clo      = 1'b1;
      row_sel  = s1_last_q;
      col_sel  = s1_last_q;
      done_sel = 1'b1;
    end
  end

  logic [SUM_W-1:0] sum_c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i != 0 || !clo) && (j != 0 || !rlo)) begin
            sum_c[k] = sum_c[k] + SUM_W'(win[i][j][k*CHANNEL_BITS +: CHANNEL_BITS]);
          end
        end
      end
    end
  end

  // Sum stage, product stage, output register.
  logic              s2_valid_q, s3_valid_q;
  logic [SUM_W-1:0]  s2_sum_q [3];
  div_e              s2_div_q, s3_div_q;
  logic [ADDR_W-1:0] s2_row_q, s2_col_q, s3_row_q, s3_col_q;
  logic              s2_done_q, s3_done_q;
  logic [PROD_W-1:0] s3_prod_q [3];
  logic [RCP_W-1:0]  rcp;
  logic [15:0]       quo [3];

  always_comb begin
    case (s2_div_q)
      DIV_9:   rcp = RCP_9;
      DIV_6:   rcp = RCP_6;
      default: rcp = RCP_4;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (s3_div_q)
        DIV_9:   quo[k] = 16'(s3_prod_q[k] >> SHIFT_9);
        DIV_6:   quo[k] = 16'(s3_prod_q[k] >> SHIFT_6);
        default: quo[k] = 16'(s3_prod_q[k] >> SHIFT_4);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s2_valid_q  <= s1_valid_q && (emit_sel != 4'b0000);
      s3_valid_q  <= s2_valid_q;
      out_valid_o <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sum_q  <= sum_c;
      s2_div_q  <= (rlo && clo) ? DIV_4 : ((rlo || clo) ? DIV_6 : DIV_9);
      s2_row_q  <= row_sel;
      s2_col_q  <= col_sel;
      s2_done_q <= done_sel;
      for (int k = 0; k < 3; k++) begin
        s3_prod_q[k] <= PROD_W'(s2_sum_q[k]) * PROD_W'(rcp);
      end
      s3_div_q     <= s2_div_q;
      s3_row_q     <= s2_row_q;
      s3_col_q     <= s2_col_q;
      s3_done_q    <= s2_done_q;
      out_red_o    <= quo[0];
      out_green_o  <= quo[1];
      out_blue_o   <= quo[2];
      out_row_o    <= s3_row_q;
      out_col_o    <= s3_col_q;
      frame_done_o <= s3_done_q;
    end
  end

endmodule

// ===== src/bb3_checker.sv =====
// Port-level assertions for the box blur, bound to the top level.
module bb3_checker import bb3_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [9:0]  out_row_o,
  input logic [9:0]  out_col_o,
  input logic        frame_done_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The frame ends on the bottom-right corner, which lies on the diagonal.
  a_done_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> out_row_o == out_col_o && out_row_o != 10'd0)
    else $error("frame end off the corner");

  // Two frame ends never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && !out_stall_i |=> !(out_valid_o && frame_done_o))
    else $error("repeated frame end");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_row_o    (out_row_o),
  .out_col_o    (out_col_o),
  .frame_done_o (frame_done_o)
);
